// ===== sv/cbfs_pkg.sv =====
// ---------------------------------------------------------------------------
// cbfs_pkg
// Shared constants, command codes and the status type of the ring FIFO with
// bulk discard and fill.
// ---------------------------------------------------------------------------
package cbfs_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    localparam int CMD_W     = 3;
    localparam int CNT_W     = 5;
    localparam int CFG_CAP_W = 5;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DISCARD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FILL    = 3'd4;

    // register index, taken from paddr above the byte offset
    localparam logic REG_CAPACITY = 1'b0;

    // status of one request, from the command unit to the result stage
    typedef struct packed {
        logic             accepted;
        logic             mem_we;
        logic             mem_re;
        logic [CNT_W-1:0] done_count;
        logic [CNT_W-1:0] level;
        logic             is_full;
        logic             is_empty;
    } ctrl_t;

endpackage

// ===== sv/cbfs_if.sv =====
// ---------------------------------------------------------------------------
// cbfs_if
// Request and result channels: valid/ready handshake with payload.
// ---------------------------------------------------------------------------
interface cbfs_in_if #(
    parameter int WIDTH = cbfs_pkg::WIDTH_DEF
);
    logic                       valid;
    logic                       ready;
    logic [cbfs_pkg::CMD_W-1:0] cmd;
    logic [WIDTH-1:0]           push_data;
    logic [cbfs_pkg::CNT_W-1:0] count;

    modport source (output valid, output cmd, output push_data, output count, input ready);
    modport sink   (input valid, input cmd, input push_data, input count, output ready);
endinterface

interface cbfs_out_if #(
    parameter int WIDTH = cbfs_pkg::WIDTH_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [WIDTH-1:0]           read_data;
    logic [cbfs_pkg::CNT_W-1:0] done_count;
    logic [cbfs_pkg::CNT_W-1:0] level;
    logic                       is_full;
    logic                       is_empty;

    modport source (output valid, output accepted, output read_data, output done_count,
                    output level, output is_full, output is_empty, input ready);
    modport sink   (input valid, input accepted, input read_data, input done_count,
                    input level, input is_full, input is_empty, output ready);
endinterface

// ===== sv/cbfs_cmd_unit.sv =====
// ---------------------------------------------------------------------------
// cbfs_cmd_unit
// Decodes one request against the pointer state: next pointers, store
// access and the status reported with the result.
// ---------------------------------------------------------------------------
module cbfs_cmd_unit #(
    parameter int DEPTH = cbfs_pkg::DEPTH_DEF
) (
    input  logic [cbfs_pkg::CMD_W-1:0]  cmd,
    input  logic [cbfs_pkg::CNT_W-1:0]  count,
    input  logic [$clog2(DEPTH)-1:0]    rp,
    input  logic [$clog2(DEPTH)-1:0]    wp,
    input  logic                        last,
    input  logic [$clog2(DEPTH+1)-1:0]  cap,
    output logic [$clog2(DEPTH)-1:0]    rp_next,
    output logic [$clog2(DEPTH)-1:0]    wp_next,
    output logic                        last_next,
    output logic [$clog2(DEPTH)-1:0]    raddr,
    output cbfs_pkg::ctrl_t             ctrl
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int LW = (CW > cbfs_pkg::CNT_W) ? CW : cbfs_pkg::CNT_W;

    // pointer + n stays below twice the capacity
    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p, input logic [CW-1:0] n,
                                           input logic [CW-1:0] c);
        logic [CW:0] s;
        s = {1'b0, CW'(p)} + {1'b0, n};
        if (s >= {1'b0, c})
            s = s - {1'b0, c};
        return s[PW-1:0];
    endfunction

    function automatic logic [CW-1:0] level_of(input logic [PW-1:0] r, input logic [PW-1:0] w,
                                               input logic l, input logic [CW-1:0] c);
        if (r == w)
            return l ? c : '0;
        else if (r < w)
            return CW'(w - r);
        else
            return c - CW'(r - w);
    endfunction

    logic [CW-1:0] lvl;
    logic [CW-1:0] lvl_new;
    logic [LW-1:0] lvl_x;
    logic [LW-1:0] lvl_new_x;
    logic [LW-1:0] cnt_x;
    logic [LW-1:0] free_x;
    logic [LW-1:0] n_x;
    logic [LW-1:0] done_x;

    always_comb
    begin
        lvl       = level_of(rp, wp, last, cap);
        lvl_x     = LW'(lvl);
        cnt_x     = LW'(count);
        free_x    = LW'(cap - lvl);
        n_x       = '0;
        done_x    = '0;
        rp_next   = rp;
        wp_next   = wp;
        last_next = last;
        raddr     = rp;
        ctrl      = '0;

        case (cmd)
            cbfs_pkg::CMD_PUSH:
            begin
                if (!(rp == wp && last))
                begin
                    ctrl.mem_we   = 1'b1;
                    ctrl.accepted = 1'b1;
                    wp_next       = wrap(wp, CW'(1), cap);
                    last_next     = 1'b1;
                end
            end
            cbfs_pkg::CMD_POP:
            begin
                if (lvl != '0)
                begin
                    ctrl.mem_re   = 1'b1;
                    ctrl.accepted = 1'b1;
                    raddr         = rp;
                    rp_next       = wrap(rp, CW'(1), cap);
                    last_next     = 1'b0;
                end
            end
            cbfs_pkg::CMD_PEEK:
            begin
                if (cnt_x < lvl_x)
                begin
                    ctrl.mem_re   = 1'b1;
                    ctrl.accepted = 1'b1;
                    raddr         = wrap(rp, CW'(cnt_x), cap);
                end
            end
            cbfs_pkg::CMD_DISCARD:
            begin
                n_x     = (cnt_x < lvl_x) ? cnt_x : lvl_x;
                rp_next = wrap(rp, CW'(n_x), cap);
                if (n_x != '0)
                    last_next = 1'b0;
                done_x  = n_x;
            end
            cbfs_pkg::CMD_FILL:
            begin
                n_x     = (cnt_x < free_x) ? cnt_x : free_x;
                wp_next = wrap(wp, CW'(n_x), cap);
                if (n_x != '0)
                    last_next = 1'b1;
                done_x  = n_x;
            end
            default:
            begin
            end
        endcase

        lvl_new         = level_of(rp_next, wp_next, last_next, cap);
        lvl_new_x       = LW'(lvl_new);
        ctrl.level      = lvl_new_x[cbfs_pkg::CNT_W-1:0];
        ctrl.done_count = done_x[cbfs_pkg::CNT_W-1:0];
        ctrl.is_full    = (rp_next == wp_next) && last_next;
        ctrl.is_empty   = (rp_next == wp_next) && !last_next;
    end

endmodule

// ===== sv/circular_fifo_with_bulk_skip_top.sv =====
// ---------------------------------------------------------------------------
// circular_fifo_with_bulk_skip_top
// Ring FIFO over a synchronous store, with push, pop, peek, bulk discard
// and bulk fill, and a capacity register on an APB-style port.
// ---------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    cmd, push_data, count
//  out_ch    out   valid / ready    accepted, read_data, done_count, level,
//                                   is_full, is_empty
//  apb       in    psel / penable   paddr, pwdata, prdata (pready tied high)
//
//  One request per cycle while the output is not stalled; its result passes
//  through the result stage (store read data and status) to the output register.
//  Pointers update at acceptance, so a following request sees them at once.
//  Reset clears pointers and flags at once; the store has no clearing pass.
//  A stalled output holds the result stage, and input ready drops behind it.
// ---------------------------------------------------------------------------
module circular_fifo_with_bulk_skip_top #(
    parameter int DEPTH = cbfs_pkg::DEPTH_DEF,
    parameter int WIDTH = cbfs_pkg::WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cbfs_in_if.sink                       in_ch,
    cbfs_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [cbfs_pkg::PDATA_W-1:0]  pwdata,
    output logic [cbfs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);
    localparam int LW = (CW > cbfs_pkg::CFG_CAP_W) ? CW : cbfs_pkg::CFG_CAP_W;

    logic [PW-1:0]    rp_reg, wp_reg, rp_next, wp_next, raddr;
    logic             last_reg, last_next;
    logic [CW-1:0]    cap_reg, cap_next;
    logic [LW-1:0]    cfg_v;
    logic             cfg_we;
    cbfs_pkg::ctrl_t  ctrl;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    logic             p_valid_reg;
    cbfs_pkg::ctrl_t  p_ctrl_reg;
    logic             p_adv;
    logic             in_take;
    logic             out_valid_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite
                 && (paddr[cbfs_pkg::PADDR_W-1:2] == cbfs_pkg::REG_CAPACITY);
    assign prdata = (paddr[cbfs_pkg::PADDR_W-1:2] == cbfs_pkg::REG_CAPACITY)
                  ? cbfs_pkg::PDATA_W'(cap_reg) : '0;

    always_comb
    begin
        cfg_v = LW'(pwdata[cbfs_pkg::CFG_CAP_W-1:0]);
        if (cfg_v == '0)
            cap_next = CW'(1);
        else if (cfg_v > LW'(DEPTH))
            cap_next = CW'(DEPTH);
        else
            cap_next = CW'(cfg_v);
    end

    // ---------------- request decode ----------------
    cbfs_cmd_unit #(
        .DEPTH (DEPTH)
    ) u_cmd (
        .cmd       (in_ch.cmd),
        .count     (in_ch.count),
        .rp        (rp_reg),
        .wp        (wp_reg),
        .last      (last_reg),
        .cap       (cap_reg),
        .rp_next   (rp_next),
        .wp_next   (wp_next),
        .last_next (last_next),
        .raddr     (raddr),
        .ctrl      (ctrl)
    );

    assign p_adv       = p_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !p_valid_reg || p_adv;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg   <= '0;
            wp_reg   <= '0;
            last_reg <= 1'b0;
            cap_reg  <= CW'(DEPTH);
        end
        else if (cfg_we)
        begin
            // a capacity write empties the queue, store contents stay
            rp_reg   <= '0;
            wp_reg   <= '0;
            last_reg <= 1'b0;
            cap_reg  <= cap_next;
        end
        else if (in_take)
        begin
            rp_reg   <= rp_next;
            wp_reg   <= wp_next;
            last_reg <= last_next;
        end
    end

    // ---------------- store ----------------
    // one request per edge, so a write and a read never share a cycle;
    // a read right after a write to the same entry sees the new word
    always_ff @(posedge clk)
    begin
        if (in_take && ctrl.mem_we)
            mem[wp_reg] <= in_ch.push_data;
        if (in_take && ctrl.mem_re)
            rdata_reg <= mem[raddr];
    end

    // ---------------- result stages ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (in_take)
            p_valid_reg <= 1'b1;
        else if (p_adv)
            p_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            p_ctrl_reg <= ctrl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (p_adv)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            out_ch.accepted   <= p_ctrl_reg.accepted;
            out_ch.read_data  <= p_ctrl_reg.mem_re ? rdata_reg : '0;
            out_ch.done_count <= p_ctrl_reg.done_count;
            out_ch.level      <= p_ctrl_reg.level;
            out_ch.is_full    <= p_ctrl_reg.is_full;
            out_ch.is_empty   <= p_ctrl_reg.is_empty;
        end
    end

    assign out_ch.valid = out_valid_reg;

    // ---------------- assertions ----------------
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(rp_reg) < cap_reg) && (CW'(wp_reg) < cap_reg))
        else $error("pointer beyond capacity");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && !p_adv) |=> p_valid_reg)
        else $error("result stage lost a pending request");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !(out_ch.is_full && out_ch.is_empty))
        else $error("full and empty together");

    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.is_empty) |-> (out_ch.level == '0))
        else $error("empty with nonzero level");

    a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.accepted) |-> (out_ch.read_data == '0))
        else $error("read data on a refused request");

endmodule

// ===== verif/cbfs_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cbfs_result_checker
// Watches the request, result and register channels of the ring FIFO, keeps
// its own copy of the queue state and compares every result, field by field,
// with the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module cbfs_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    cbfs_in_if                            in_ch,
    cbfs_out_if                           out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbfs_pkg::PADDR_W-1:0]  paddr,
    input  logic [cbfs_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending,
    output int                            result_count,
    output int                            full_count,
    output int                            empty_count
);

    localparam int DATA_W    = cbfs_pkg::WIDTH_DEF;
    localparam int STORE_N   = cbfs_pkg::DEPTH_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic                       accepted;
        logic [DATA_W-1:0]          read_data;
        logic [cbfs_pkg::CNT_W-1:0] done_count;
        logic [cbfs_pkg::CNT_W-1:0] level;
        logic                       is_full;
        logic                       is_empty;
    } fifo_status_t;

    // shadow of the queue
    logic [DATA_W-1:0]              shadow_mem [STORE_N];
    logic [3:0]                     rd_ptr;
    logic [3:0]                     wr_ptr;
    logic                           last_push;
    logic [cbfs_pkg::CFG_CAP_W-1:0] cap;

    fifo_status_t awaited_results [$];
    fifo_status_t got;
    fifo_status_t want;
    int           errors;
    int           results;
    int           fulls;
    int           empties;

    function automatic logic [3:0] wrap_ptr(logic [3:0] p, int n);
        return 4'((int'(p) + n) % int'(cap));
    endfunction

    function automatic logic [cbfs_pkg::CNT_W-1:0] fill_level();
        if (rd_ptr == wr_ptr)
            return last_push ? cap : '0;
        if (rd_ptr < wr_ptr)
            return cbfs_pkg::CNT_W'(wr_ptr - rd_ptr);
        return cbfs_pkg::CNT_W'(int'(cap) - (int'(rd_ptr) - int'(wr_ptr)));
    endfunction

    function automatic fifo_status_t predict_result(logic [cbfs_pkg::CMD_W-1:0] cmd,
                                                    logic [DATA_W-1:0] data,
                                                    logic [cbfs_pkg::CNT_W-1:0] cnt);
        fifo_status_t               r;
        logic [cbfs_pkg::CNT_W-1:0] lvl;
        int                         n;
        r   = '0;
        lvl = fill_level();
        case (cmd)
            cbfs_pkg::CMD_PUSH:
                if (!(rd_ptr == wr_ptr && last_push))
                begin
                    shadow_mem[wr_ptr] = data;
                    wr_ptr     = wrap_ptr(wr_ptr, 1);
                    last_push  = 1'b1;
                    r.accepted = 1'b1;
                end
            cbfs_pkg::CMD_POP:
                if (lvl > 0)
                begin
                    r.read_data = shadow_mem[rd_ptr];
                    rd_ptr      = wrap_ptr(rd_ptr, 1);
                    last_push   = 1'b0;
                    r.accepted  = 1'b1;
                end
            cbfs_pkg::CMD_PEEK:
                if (cnt < lvl)
                begin
                    r.read_data = shadow_mem[wrap_ptr(rd_ptr, int'(cnt))];
                    r.accepted  = 1'b1;
                end
            cbfs_pkg::CMD_DISCARD:
            begin
                n = (cnt < lvl) ? int'(cnt) : int'(lvl);
                rd_ptr = wrap_ptr(rd_ptr, n);
                if (n > 0)
                    last_push = 1'b0;
                r.done_count = cbfs_pkg::CNT_W'(n);
            end
            cbfs_pkg::CMD_FILL:
            begin
                n = int'(cap) - int'(lvl);
                if (int'(cnt) < n)
                    n = int'(cnt);
                wr_ptr = wrap_ptr(wr_ptr, n);
                if (n > 0)
                    last_push = 1'b1;
                r.done_count = cbfs_pkg::CNT_W'(n);
            end
            default: ;
        endcase
        r.level    = fill_level();
        r.is_full  = (rd_ptr == wr_ptr) && last_push;
        r.is_empty = (rd_ptr == wr_ptr) && !last_push;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr        = '0;
            wr_ptr        = '0;
            last_push     = 1'b0;
            cap           = cbfs_pkg::CFG_CAP_W'(STORE_N);
            awaited_results.delete();
            errors        = 0;
            results       = 0;
            fulls         = 0;
            empties       = 0;
            fail_count   <= 0;
            pending      <= 0;
            result_count <= 0;
            full_count   <= 0;
            empty_count  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && paddr[cbfs_pkg::PADDR_W-1:2] == cbfs_pkg::REG_CAPACITY)
            begin
                // out-of-range values clamp; a write empties the queue
                if (pwdata[cbfs_pkg::CFG_CAP_W-1:0] == 0)
                    cap = cbfs_pkg::CFG_CAP_W'(1);
                else if (pwdata[cbfs_pkg::CFG_CAP_W-1:0] > STORE_N)
                    cap = cbfs_pkg::CFG_CAP_W'(STORE_N);
                else
                    cap = pwdata[cbfs_pkg::CFG_CAP_W-1:0];
                rd_ptr    = '0;
                wr_ptr    = '0;
                last_push = 1'b0;
            end

            if (out_ch.valid && out_ch.ready)
            begin
                got.accepted   = out_ch.accepted;
                got.read_data  = out_ch.read_data;
                got.done_count = out_ch.done_count;
                got.level      = out_ch.level;
                got.is_full    = out_ch.is_full;
                got.is_empty   = out_ch.is_empty;
                results++;
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("[%0t] result %0d with no request outstanding", $realtime,
                                 results);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.is_full)
                        fulls++;
                    if (want.is_empty)
                        empties++;
                    if (got.accepted !== want.accepted || got.read_data !== want.read_data ||
                        got.done_count !== want.done_count || got.level !== want.level ||
                        got.is_full !== want.is_full || got.is_empty !== want.is_empty)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                        begin
                            $display("[%0t] result %0d mismatch: exp acc=%0b data=%h done=%0d lvl=%0d full=%0b empty=%0b",
                                     $realtime, results,
                                     want.accepted, want.read_data, want.done_count,
                                     want.level, want.is_full, want.is_empty);
                            $display("    got acc=%0b data=%h done=%0d lvl=%0d full=%0b empty=%0b",
                                     got.accepted, got.read_data, got.done_count,
                                     got.level, got.is_full, got.is_empty);
                        end
                    end
                end
            end

            if (in_ch.valid && in_ch.ready)
                awaited_results.push_back(predict_result(in_ch.cmd, in_ch.push_data,
                                                         in_ch.count));

            fail_count   <= errors;
            pending      <= awaited_results.size();
            result_count <= results;
            full_count   <= fulls;
            empty_count  <= empties;
        end
    end

endmodule

// ===== verif/tb_circular_fifo_with_bulk_skip_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_circular_fifo_with_bulk_skip_top
// Drives the ring FIFO with a directed sequence and then biased random
// requests over several capacity settings and flow-control mixes; the
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_circular_fifo_with_bulk_skip_top;

    localparam int DATA_W      = cbfs_pkg::WIDTH_DEF;
    localparam int SEGMENTS    = 8;
    localparam int SEG_ITEMS   = 225;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [cbfs_pkg::CMD_W-1:0] CMD_LAST = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [cbfs_pkg::PADDR_W-1:0]  paddr;
    logic [cbfs_pkg::PDATA_W-1:0]  pwdata;
    logic [cbfs_pkg::PDATA_W-1:0]  prdata;
    logic                          pready;

    int fail_count;
    int pending;
    int result_count;
    int full_count;
    int empty_count;

    int idle_pct  = 0;
    int stall_pct = 0;
    int sent      = 0;
    int cap_writes = 0;
    int quiet     = 0;

    logic [cbfs_pkg::CFG_CAP_W-1:0] cap_plan [SEGMENTS];

    cbfs_in_if  #(.WIDTH(DATA_W)) in_ch ();
    cbfs_out_if #(.WIDTH(DATA_W)) out_ch ();

    circular_fifo_with_bulk_skip_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cbfs_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .full_count   (full_count),
        .empty_count  (empty_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    task automatic send_request(input logic [cbfs_pkg::CMD_W-1:0] cmd,
                                input logic [DATA_W-1:0] data,
                                input logic [cbfs_pkg::CNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.push_data <= data;
        in_ch.count     <= cnt;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent++;
    endtask

    // the extra edge lets the checker count the last accepted request
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [cbfs_pkg::CFG_CAP_W-1:0] value);
        logic [cbfs_pkg::PDATA_W-1:0] word;
        word = $urandom();
        word[cbfs_pkg::CFG_CAP_W-1:0] = value;
        wait_drained();
        repeat (3) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {cbfs_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cap_writes++;
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no request or result moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int                          r;
        int                          bias;
        int                          p_push, p_pop, p_peek, p_disc, p_fill;
        logic [cbfs_pkg::CMD_W-1:0]  cmd;
        logic [cbfs_pkg::CNT_W-1:0]  cnt;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= cbfs_pkg::CMD_PUSH;
        in_ch.push_data <= '0;
        in_ch.count     <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cap_plan = '{5'd16, 5'd0, 5'd5, 5'd31, 5'd1, 5'd2, 5'd17, 5'd9};
        cap_plan[SEGMENTS-1] = cbfs_pkg::CFG_CAP_W'($urandom_range(3, 15));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty corner cases, then write every store entry before any read
        send_request(cbfs_pkg::CMD_POP, '0, '0);
        send_request(cbfs_pkg::CMD_PEEK, '0, '0);
        send_request(cbfs_pkg::CMD_DISCARD, '0, 5'd5);
        send_request(cbfs_pkg::CMD_PUSH, '0, '0);
        send_request(cbfs_pkg::CMD_PUSH, '1, '1);
        for (int i = 0; i < 14; i++)
            send_request(cbfs_pkg::CMD_PUSH, $urandom(), cbfs_pkg::CNT_W'(i));
        send_request(cbfs_pkg::CMD_PUSH, 32'hA5A5_5A5A, '0);   // refused, queue full
        send_request(cbfs_pkg::CMD_FILL, '0, 5'd3);            // no room: clamps to zero
        send_request(cbfs_pkg::CMD_PEEK, '0, 5'd15);
        send_request(cbfs_pkg::CMD_PEEK, '0, 5'd16);
        send_request(cbfs_pkg::CMD_POP, '0, '0);
        send_request(cbfs_pkg::CMD_DISCARD, '0, 5'd31);
        send_request(cbfs_pkg::CMD_FILL, '0, 5'd31);           // filled slots read old contents
        send_request(CMD_LAST, $urandom(), '1);
        send_request(cbfs_pkg::CMD_POP, '0, '0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            write_capacity(cap_plan[seg]);
            idle_pct  = (seg % 4 == 1) ? 59 : (seg % 4 == 3) ? 12 : 0;
            stall_pct = (seg % 4 == 2) ? 59 : (seg % 4 == 3) ? 12 : 0;
            bias = 0;
            for (int k = 0; k < SEG_ITEMS; k++)
            begin
                if (k % 32 == 0)
                    bias = $urandom_range(0, 2);
                if (k == SEG_ITEMS / 2)
                    wait_drained();
                // push-heavy, pop-heavy or balanced stretches sweep the level
                case (bias)
                    0:       begin p_push = 55; p_pop = 70; p_peek = 80; p_disc = 87; p_fill = 95; end
                    1:       begin p_push = 15; p_pop = 60; p_peek = 75; p_disc = 87; p_fill = 92; end
                    default: begin p_push = 35; p_pop = 65; p_peek = 82; p_disc = 90; p_fill = 96; end
                endcase
                r = $urandom_range(0, 99);
                if (r < p_push)
                    cmd = cbfs_pkg::CMD_PUSH;
                else if (r < p_pop)
                    cmd = cbfs_pkg::CMD_POP;
                else if (r < p_peek)
                    cmd = cbfs_pkg::CMD_PEEK;
                else if (r < p_disc)
                    cmd = cbfs_pkg::CMD_DISCARD;
                else if (r < p_fill)
                    cmd = cbfs_pkg::CMD_FILL;
                else
                    cmd = cbfs_pkg::CMD_W'($urandom_range(int'(cbfs_pkg::CMD_FILL) + 1,
                                                          int'(CMD_LAST)));
                r = $urandom_range(0, 99);
                if (r < 60)
                    cnt = cbfs_pkg::CNT_W'($urandom_range(0, 4));
                else if (r < 90)
                    cnt = cbfs_pkg::CNT_W'($urandom_range(0, 16));
                else
                    cnt = cbfs_pkg::CNT_W'($urandom_range(0, 31));
                send_request(cmd, $urandom(), cnt);
            end
        end

        wait_drained();
        repeat (3) @(posedge clk);

        $display("Sent %0d requests, checked %0d results over %0d capacity writes",
                 sent, result_count, cap_writes);
        $display("with mixed gaps and back-pressure; queue full %0d times, empty %0d times.",
                 full_count, empty_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
